/* src/slc_pkg.sv */
// shared types, widths and constants of the triangle contour slicer
// no dependencies; imported by every module of the block
`default_nettype none

package slc_pkg;

	localparam int COORD_W   = 24;
	localparam int SCR_W     = 16;
	localparam int LVL_W     = 24;
	localparam int SPACING_W = 23;
	localparam int CNT_W     = 7;
	// signed width of a height difference or a level height
	localparam int ZW        = 25;
	// signed width of half screen in fixed point plus 200 times a coordinate
	localparam int BW        = 34;
	// signed width of 200 times a coordinate difference
	localparam int DW        = 33;
	// quotient bits of the projection divider
	localparam int QB        = 16;
	localparam int QDEPTH    = 2;

	localparam logic [SPACING_W-1:0] SPACING_RESET = 23'd6554;
	localparam logic [SCR_W-1:0]     SAT_MAX       = 16'h7fff;
	localparam logic [SCR_W-1:0]     SAT_MIN       = 16'h8000;

	localparam int SCREEN_SIZE_DEF     = 512;
	localparam int MAX_STRIPES_DEF     = 64;
	localparam int COORD_FRAC_BITS_DEF = 16;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} vertex_t;

	// one classified triangle, handed from front to back
	typedef struct packed {
		vertex_t               hv;
		vertex_t               mv;
		vertex_t               lv;
		logic [ZW-1:0]         lvl0;
		logic [LVL_W-1:0]      idx0;
		logic [CNT_W-1:0]      n;
		logic                  trunc;
		logic [SPACING_W-1:0]  sp;
	} desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIVL,
		F_DIVH,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_OPS,
		B_MUL,
		B_SUM,
		B_PREP,
		B_DIV,
		B_NEXT,
		B_EMIT
	} back_state_t;

endpackage

`default_nettype wire

/* src/slc_fifo.sv */
// two-entry descriptor queue between front and back
// depends on slc_pkg
`default_nettype none

module slc_fifo
	import slc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire desc_t   wdata,
	input  wire logic    pop,
	output desc_t        rdata,
	output q_stat_t      stat
);

	localparam int PW = $clog2(QDEPTH);

	desc_t             mem_q [QDEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [PW:0]       cnt_q;

	assign stat.full  = (cnt_q == (PW+1)'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* src/slc_front.sv */
// front end: takes a triangle, sorts vertices by height, finds the level range
// depends on slc_pkg; feeds slc_fifo
`default_nettype none

module slc_front
	import slc_pkg::*;
#(
	parameter int MAX_STRIPES = MAX_STRIPES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [COORD_W-1:0]    p_x,
	input  wire logic [COORD_W-1:0]    p_y,
	input  wire logic [COORD_W-1:0]    p_z,
	input  wire logic [COORD_W-1:0]    q_x,
	input  wire logic [COORD_W-1:0]    q_y,
	input  wire logic [COORD_W-1:0]    q_z,
	input  wire logic [COORD_W-1:0]    r_x,
	input  wire logic [COORD_W-1:0]    r_y,
	input  wire logic [COORD_W-1:0]    r_z,
	input  wire logic [SPACING_W-1:0]  spacing,
	input  wire q_stat_t               qstat,
	output logic                       push,
	output desc_t                      desc
);

	localparam int DCW = $clog2(COORD_W);

	front_state_t          state_q, state_d;
	vertex_t               hv_q, mv_q, lv_q;
	logic [SPACING_W-1:0]  sp_q;
	logic [DCW-1:0]        dcnt_q;
	logic [SPACING_W-1:0]  rem_q;
	logic [COORD_W-1:0]    quo_q;
	logic [COORD_W-1:0]    mag_q;
	logic                  neg_q;
	logic [ZW-1:0]         lo_q;
	logic [ZW-1:0]         lvl0_q;
	logic [ZW:0]           count_q;

	vertex_t               s0, s1, s2, t0, t1, t2, u1, u2;
	logic [COORD_W-1:0]    trial;
	logic                  ge;
	logic [COORD_W-1:0]    new_rem;
	logic [COORD_W-1:0]    q_fin;
	logic [SPACING_W-1:0]  r_fin;
	logic [ZW-1:0]         fq;
	logic [ZW-1:0]         zl;
	logic [ZW-1:0]         lvl0_fin;
	logic                  accept;
	logic                  div_done;

	// compare-and-swap network on height
	always_comb begin
		s0 = '{x: p_x, y: p_y, z: p_z};
		s1 = '{x: q_x, y: q_y, z: q_z};
		s2 = '{x: r_x, y: r_y, z: r_z};
		if ($signed(s0.z) < $signed(s1.z)) begin
			t0 = s1;
			t1 = s0;
		end else begin
			t0 = s0;
			t1 = s1;
		end
		t2 = s2;
		if ($signed(t0.z) < $signed(t2.z)) begin
			u2 = t0;
			t0 = t2;
		end else begin
			u2 = t2;
		end
		u1 = t1;
		if ($signed(u1.z) < $signed(u2.z)) begin
			t1 = u2;
			t2 = u1;
		end else begin
			t1 = u1;
			t2 = u2;
		end
	end

	// one bit of restoring division per cycle
	always_comb begin
		trial    = {rem_q, mag_q[COORD_W-1]};
		ge       = (trial >= {1'b0, sp_q});
		new_rem  = ge ? (trial - {1'b0, sp_q}) : trial;
		q_fin    = {quo_q[COORD_W-2:0], ge};
		r_fin    = new_rem[SPACING_W-1:0];
		// floor toward minus infinity; minus q minus one is the complement
		if (!neg_q) begin
			fq = {1'b0, q_fin};
		end else if (r_fin != '0) begin
			fq = ~{1'b0, q_fin};
		end else begin
			fq = -{1'b0, q_fin};
		end
		zl = {lv_q.z[COORD_W-1], lv_q.z};
		// height of the first level above the low vertex
		if (!neg_q) begin
			lvl0_fin = zl - ZW'(r_fin) + ZW'(sp_q);
		end else if (r_fin != '0) begin
			lvl0_fin = zl + ZW'(r_fin);
		end else begin
			lvl0_fin = zl + ZW'(sp_q);
		end
	end

	assign div_done = (dcnt_q == DCW'(COORD_W-1));
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (in_valid && spacing != '0) begin
					state_d = F_DIVL;
				end
			end
			F_DIVL: begin
				if (div_done) begin
					state_d = F_DIVH;
				end
			end
			F_DIVH: begin
				if (div_done) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if ($signed(count_q) <= 0 || !qstat.full) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == F_IDLE);
		push     = (state_q == F_PUSH) && ($signed(count_q) > 0) && !qstat.full;
	end

	always_comb begin
		desc.hv    = hv_q;
		desc.mv    = mv_q;
		desc.lv    = lv_q;
		desc.lvl0  = lvl0_q;
		desc.idx0  = LVL_W'(lo_q + 1'b1);
		desc.trunc = ($signed(count_q) > $signed((ZW+1)'(MAX_STRIPES)));
		desc.n     = desc.trunc ? CNT_W'(MAX_STRIPES) : count_q[CNT_W-1:0];
		desc.sp    = sp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					hv_q   <= t0;
					mv_q   <= t1;
					lv_q   <= t2;
					sp_q   <= spacing;
					neg_q  <= t2.z[COORD_W-1];
					mag_q  <= t2.z[COORD_W-1] ? -t2.z : t2.z;
					rem_q  <= '0;
					quo_q  <= '0;
					dcnt_q <= '0;
				end
			end
			F_DIVL, F_DIVH: begin
				rem_q  <= r_fin;
				quo_q  <= q_fin;
				mag_q  <= mag_q << 1;
				dcnt_q <= dcnt_q + 1'b1;
				if (div_done) begin
					dcnt_q <= '0;
					rem_q  <= '0;
					quo_q  <= '0;
					if (state_q == F_DIVL) begin
						lo_q   <= fq;
						lvl0_q <= lvl0_fin;
						neg_q  <= hv_q.z[COORD_W-1];
						mag_q  <= hv_q.z[COORD_W-1] ? -hv_q.z : hv_q.z;
					end else begin
						count_q <= {fq[ZW-1], fq} - {lo_q[ZW-1], lo_q};
					end
				end
			end
			F_PUSH: begin
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* src/slc_back.sv */
// back end: walks the levels of one triangle, projects both crossing points
// depends on slc_pkg; fed by slc_fifo, drives the result register
`default_nettype none

module slc_back
	import slc_pkg::*;
#(
	parameter int SCREEN_SIZE     = SCREEN_SIZE_DEF,
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire desc_t              desc,
	input  wire q_stat_t            qstat,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [SCR_W-1:0]        start_col,
	output logic [SCR_W-1:0]        start_row,
	output logic [SCR_W-1:0]        end_col,
	output logic [SCR_W-1:0]        end_row,
	output logic [LVL_W-1:0]        level_index,
	output logic                    last,
	output logic                    truncated
);

	localparam int TW = BW + ZW + 1;
	localparam int NW = TW - COORD_FRAC_BITS;
	localparam int HW = NW - QB;
	localparam logic signed [BW-1:0] HALF_FIX = BW'(SCREEN_SIZE / 2) << COORD_FRAC_BITS;

	back_state_t            state_q, state_d;
	desc_t                  d_q;
	logic signed [ZW-1:0]   lvl_q;
	logic [LVL_W-1:0]       idx_q;
	logic [CNT_W-1:0]       left_q;
	logic [1:0]             j_q;
	logic signed [BW-1:0]   base_s1;
	logic signed [ZW-1:0]   den_s1;
	logic signed [DW-1:0]   dc_s1;
	logic signed [ZW-1:0]   dl_s1;
	logic signed [BW+ZW-1:0] m1_s2;
	logic signed [DW+ZW-1:0] m2_s2;
	logic signed [TW-1:0]   t_s3;
	logic                   neg_q;
	logic                   ovf_q;
	logic [NW-1:0]          rem_q;
	logic [NW-1:0]          ds_q;
	logic [QB-1:0]          quo_q;
	logic [$clog2(QB)-1:0]  dcnt_q;
	logic [SCR_W-1:0]       res_q [4];
	logic                   out_valid_q;

	logic [COORD_W-1:0]     a_c, b_c, a_z, b_z;
	logic signed [BW-1:0]   ac_w;
	logic signed [DW-1:0]   dcw;
	logic [TW-1:0]          tmag;
	logic                   dge;
	logic [SCR_W-1:0]       sat_v;
	logic                   load_out;

	// operand selection: long edge for the start point, short edge for the end
	always_comb begin
		vertex_t va, vb;
		va = d_q.lv;
		vb = d_q.hv;
		if (j_q[1]) begin
			if (lvl_q <= $signed({d_q.mv.z[COORD_W-1], d_q.mv.z})) begin
				vb = d_q.mv;
			end else begin
				va = d_q.mv;
			end
		end
		a_c  = j_q[0] ? va.y : va.x;
		b_c  = j_q[0] ? vb.y : vb.x;
		a_z  = va.z;
		b_z  = vb.z;
		ac_w = BW'($signed(a_c));
		dcw  = DW'($signed({b_c[COORD_W-1], b_c}) - $signed({a_c[COORD_W-1], a_c}));
	end

	always_comb begin
		tmag  = t_s3[TW-1] ? TW'(-t_s3) : TW'(t_s3);
		dge   = (rem_q >= ds_q);
		if (ovf_q) begin
			sat_v = neg_q ? SAT_MIN : SAT_MAX;
		end else if (!neg_q) begin
			sat_v = quo_q[QB-1] ? SAT_MAX : quo_q;
		end else begin
			sat_v = (quo_q > SAT_MIN) ? SAT_MIN : SCR_W'(-quo_q);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!qstat.empty) begin
					state_d = B_OPS;
				end
			end
			B_OPS:  state_d = B_MUL;
			B_MUL:  state_d = B_SUM;
			B_SUM:  state_d = B_PREP;
			B_PREP: state_d = B_DIV;
			B_DIV: begin
				if (dcnt_q == '1) begin
					state_d = B_NEXT;
				end
			end
			B_NEXT: state_d = (j_q == 2'd3) ? B_EMIT : B_OPS;
			B_EMIT: begin
				if (!out_valid_q || out_ready) begin
					state_d = (left_q == CNT_W'(1)) ? B_IDLE : B_OPS;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop      = (state_q == B_IDLE) && !qstat.empty;
		load_out = (state_q == B_EMIT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (pop) begin
					d_q    <= desc;
					lvl_q  <= $signed(desc.lvl0);
					idx_q  <= desc.idx0;
					left_q <= desc.n;
					j_q    <= '0;
				end
			end
			B_OPS: begin
				// 200 = 128 + 64 + 8
				base_s1 <= (ac_w <<< 7) + (ac_w <<< 6) + (ac_w <<< 3) + HALF_FIX;
				dc_s1   <= (dcw <<< 7) + (dcw <<< 6) + (dcw <<< 3);
				den_s1  <= $signed({b_z[COORD_W-1], b_z}) - $signed({a_z[COORD_W-1], a_z});
				dl_s1   <= lvl_q - $signed({a_z[COORD_W-1], a_z});
			end
			B_MUL: begin
				m1_s2 <= base_s1 * den_s1;
				m2_s2 <= dc_s1 * dl_s1;
			end
			B_SUM: begin
				t_s3 <= TW'(m1_s2) + TW'(m2_s2);
			end
			B_PREP: begin
				neg_q  <= t_s3[TW-1];
				rem_q  <= tmag[TW-1:COORD_FRAC_BITS];
				ovf_q  <= (tmag[TW-1:COORD_FRAC_BITS+QB] >= HW'(den_s1[COORD_W-1:0]));
				ds_q   <= NW'(den_s1[COORD_W-1:0]) << (QB - 1);
				quo_q  <= '0;
				dcnt_q <= '0;
			end
			B_DIV: begin
				if (dge) begin
					rem_q <= rem_q - ds_q;
				end
				quo_q  <= {quo_q[QB-2:0], dge};
				ds_q   <= ds_q >> 1;
				dcnt_q <= dcnt_q + 1'b1;
			end
			B_NEXT: begin
				res_q[j_q] <= sat_v;
				j_q        <= j_q + 1'b1;
			end
			B_EMIT: begin
				if (load_out) begin
					start_col   <= res_q[0];
					start_row   <= res_q[1];
					end_col     <= res_q[2];
					end_row     <= res_q[3];
					level_index <= idx_q;
					last        <= (left_q == CNT_W'(1));
					truncated   <= d_q.trunc;
					left_q      <= left_q - 1'b1;
					lvl_q       <= lvl_q + $signed(ZW'(d_q.sp));
					idx_q       <= idx_q + 1'b1;
					j_q         <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* src/triangle_contour_slicer_unit.sv */
// triangle contour slicer top level: spacing register, front, queue, back
// depends on slc_pkg, slc_front, slc_fifo, slc_back
// the front runs two 24-step floor divisions per triangle before it pushes the
// descriptor; the back makes four projections per segment (operands, multiply,
// add, prep, 16 divide steps, store), then one output load that waits for the
// result register; the queue lets the front take the next triangle meanwhile
// reset: asynchronous active low; clears both state machines, the queue and
// output valid, and loads the spacing register with 6554
`default_nettype none

module triangle_contour_slicer_unit
	import slc_pkg::*;
#(
	parameter int SCREEN_SIZE     = SCREEN_SIZE_DEF,
	parameter int MAX_STRIPES     = MAX_STRIPES_DEF,
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  stripe_spacing_we,
	input  wire logic [SPACING_W-1:0]  stripe_spacing,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [COORD_W-1:0]    p_x,
	input  wire logic [COORD_W-1:0]    p_y,
	input  wire logic [COORD_W-1:0]    p_z,
	input  wire logic [COORD_W-1:0]    q_x,
	input  wire logic [COORD_W-1:0]    q_y,
	input  wire logic [COORD_W-1:0]    q_z,
	input  wire logic [COORD_W-1:0]    r_x,
	input  wire logic [COORD_W-1:0]    r_y,
	input  wire logic [COORD_W-1:0]    r_z,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [SCR_W-1:0]           start_col,
	output logic [SCR_W-1:0]           start_row,
	output logic [SCR_W-1:0]           end_col,
	output logic [SCR_W-1:0]           end_row,
	output logic [LVL_W-1:0]           level_index,
	output logic                       last,
	output logic                       truncated
);

	// spacing register; the user must write it only while the block is idle, the block itself does not enforce this
	logic [SPACING_W-1:0] spacing_q;

	// descriptor queue signals
	desc_t   push_desc;
	desc_t   head_desc;
	logic    q_push;
	logic    q_pop;
	q_stat_t qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= SPACING_RESET;
		end else if (stripe_spacing_we) begin
			spacing_q <= stripe_spacing;
		end
	end

	// front: sorts the vertices and finds the first level and level count
	slc_front #(
		.MAX_STRIPES (MAX_STRIPES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.p_x      (p_x),
		.p_y      (p_y),
		.p_z      (p_z),
		.q_x      (q_x),
		.q_y      (q_y),
		.q_z      (q_z),
		.r_x      (r_x),
		.r_y      (r_y),
		.r_z      (r_z),
		.spacing  (spacing_q),
		.qstat    (qstat),
		.push     (q_push),
		.desc     (push_desc)
	);

	// short queue so that a new triangle can be classified while segments drain
	slc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (push_desc),
		.pop    (q_pop),
		.rdata  (head_desc),
		.stat   (qstat)
	);

	// back: one segment per level, at most MAX_STRIPES per triangle, lowest first, into the result register
	slc_back #(
		.SCREEN_SIZE     (SCREEN_SIZE),
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.desc        (head_desc),
		.qstat       (qstat),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.start_col   (start_col),
		.start_row   (start_row),
		.end_col     (end_col),
		.end_row     (end_row),
		.level_index (level_index),
		.last        (last),
		.truncated   (truncated)
	);

`ifndef SYNTH
	// the front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && qstat.full))
		else $error("descriptor pushed into full queue");

	// the back never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && qstat.empty))
		else $error("descriptor popped from empty queue");

	// with a nonzero spacing, the front is not ready in the cycle after a triangle transfer
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && stripe_spacing_we == 1'b0 && spacing_q != '0) |=> !in_ready)
		else $error("front ready right after a transfer");
`endif

endmodule

`default_nettype wire
